### design/toroidal_chunk_slot_scheduler_defines.svh
// Assertion macros shared by the chunk slot scheduler RTL.
`ifndef TOROIDAL_CHUNK_SLOT_SCHEDULER_DEFINES_SVH
`define TOROIDAL_CHUNK_SLOT_SCHEDULER_DEFINES_SVH

// Checked on clk, muted while rst_n is low.
`define TCSS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on clk at every edge, reset included.
`define TCSS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/tcss_pkg.sv
// Types, constants and helpers of the chunk slot scheduler.
`default_nettype none

package tcss_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int MAX_RADIUS  = 3;
    localparam int RAD_W       = 2;
    localparam int GRID_W      = $clog2(2 * MAX_RADIUS + 2);
    localparam int SLOT_W      = 6;
    localparam int CNT_W       = $clog2(COORD_WIDTH);
    localparam int N_LANE      = 5;
    localparam int SLOT_MAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) - 1;

    // Modulo lanes
    localparam int LANE_SX  = 0;
    localparam int LANE_SZ  = 1;
    localparam int LANE_OX  = 2;
    localparam int LANE_OZ  = 3;
    localparam int LANE_MIN = 4;

    // Output phase codes
    localparam logic [1:0] PH_INIT = 2'd0;
    localparam logic [1:0] PH_XS   = 2'd1;
    localparam logic [1:0] PH_ZS   = 2'd2;

    // Request operation codes
    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [GRID_W-1:0]             grid_t;
    typedef logic [RAD_W-1:0]              radius_t;
    typedef logic [SLOT_W-1:0]             slot_t;

    typedef struct packed {
        logic       load;
        logic       mod_step;
        logic       start_init;
        logic       start_x;
        logic       start_z;
        logic       step_i;
        logic       step_j;
        logic       row_reset;
        logic       emit;
        logic       last;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic op;
        logic xchg;
        logic zchg;
        logic row_end;
        logic col_end;
        logic can_emit;
    } stat_t;

    // Map register value to the effective radius: zero reads as one, clamp at the max.
    function automatic grid_t clamp_radius(radius_t r);
        grid_t rr;
        rr = GRID_W'(r);
        if (rr == '0)
            rr = GRID_W'(1);
        else if (rr > GRID_W'(MAX_RADIUS))
            rr = GRID_W'(MAX_RADIUS);
        return rr;
    endfunction

endpackage

`default_nettype wire

### design/tcss_intf.sv
// Channel interfaces of the chunk slot scheduler: request, result, configuration.
`default_nettype none

interface tcss_item_if import tcss_pkg::*;;
    logic   valid;
    logic   ready;
    logic   op;
    coord_t chunk_x;
    coord_t chunk_z;

    modport source (output valid, output op, output chunk_x, output chunk_z, input ready);
    modport sink   (input valid, input op, input chunk_x, input chunk_z, output ready);
endinterface

interface tcss_result_if import tcss_pkg::*;;
    logic   valid;
    logic   ready;
    slot_t  slot_index;
    coord_t new_chunk_x;
    coord_t new_chunk_z;
    logic   last;

    modport source (output valid, output slot_index, output new_chunk_x,
                    output new_chunk_z, output last, input ready);
    modport sink   (input valid, input slot_index, input new_chunk_x,
                    input new_chunk_z, input last, output ready);
endinterface

interface tcss_cfg_if import tcss_pkg::*;;
    logic    valid;
    logic    ready;
    radius_t render_radius;

    modport source (output valid, output render_radius, input ready);
    modport sink   (input valid, input render_radius, output ready);
endinterface

`default_nettype wire

### design/tcss_datapath.sv
// Datapath: position state, serial floored-modulo lanes, strip walkers, output register.
`default_nettype none

module tcss_datapath import tcss_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    cmd,
    output stat_t        stat,
    input  wire logic    item_op,
    input  wire coord_t  item_x,
    input  wire coord_t  item_z,
    input  wire logic    cfg_we,
    input  wire radius_t cfg_radius,
    input  wire logic    res_ready,
    output logic         res_valid,
    output slot_t        slot_index,
    output coord_t       new_chunk_x,
    output coord_t       new_chunk_z,
    output logic         last
);

    localparam coord_t MAX_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t MIN_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    radius_t           radius_reg;
    logic              op_reg;
    logic              xchg_reg, zchg_reg;
    coord_t            last_x_reg, last_z_reg;
    coord_t            sx_reg, sz_reg, nx_reg, nz_reg;
    coord_t            wx_reg, wx_next, wz_reg, wz_next;
    grid_t             mx_reg, mx_next, mz_reg, mz_next;
    grid_t             i_reg, j_reg;
    grid_t             g_reg, r2_reg;
    logic [CNT_W-1:0]  bit_cnt_reg;
    coord_t            sh_reg  [N_LANE];
    grid_t             rem_reg [N_LANE];
    logic              out_valid_reg;
    slot_t             slot_reg;
    coord_t            ox_reg_x, oz_reg_z;
    logic              last_reg;

    // Load-cycle values
    grid_t   r_eff, g_eff;
    coord_t  r_ext, sx_w, sz_w, ox_w, oz_w, nx_w, nz_w;
    logic    dxu, dzu;
    coord_t  opnd [N_LANE];

    // Output selection
    coord_t  sel_x, sel_z;
    grid_t   sel_mx, sel_mz;
    slot_t   slot_w;

    always_comb
    begin
        r_eff = clamp_radius(radius_reg);
        g_eff = GRID_W'({r_eff, 1'b1});
        r_ext = COORD_WIDTH'(r_eff);
        dxu   = item_x > last_x_reg;
        dzu   = item_z > last_z_reg;
        sx_w  = item_x - r_ext;
        sz_w  = item_z - r_ext;
        ox_w  = dxu ? (last_x_reg - r_ext) : (last_x_reg + r_ext);
        oz_w  = dzu ? (last_z_reg - r_ext) : (last_z_reg + r_ext);
        nx_w  = dxu ? (item_x + r_ext) : sx_w;
        nz_w  = dzu ? (item_z + r_ext) : sz_w;
        opnd[LANE_SX]  = sx_w;
        opnd[LANE_SZ]  = sz_w;
        opnd[LANE_OX]  = ox_w;
        opnd[LANE_OZ]  = oz_w;
        opnd[LANE_MIN] = MIN_NEG;
    end

    // Serial floored modulo, MSB first; the sign bit carries weight minus one.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N_LANE; k++)
        begin
            if (cmd.load)
            begin
                rem_reg[k] <= opnd[k][COORD_WIDTH-1] ? g_eff - GRID_W'(1) : '0;
                sh_reg[k]  <= opnd[k] << 1;
            end
            else if (cmd.mod_step)
            begin
                logic [GRID_W:0] t;
                t = {rem_reg[k], sh_reg[k][COORD_WIDTH-1]};
                if (t >= {1'b0, g_reg})
                    t = t - {1'b0, g_reg};
                rem_reg[k] <= GRID_W'(t);
                sh_reg[k]  <= sh_reg[k] << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RAD_W'(1);
            last_x_reg  <= '0;
            last_z_reg  <= '0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                radius_reg <= cfg_radius;
            if (cmd.load)
            begin
                last_x_reg  <= item_x;
                last_z_reg  <= item_z;
                bit_cnt_reg <= CNT_W'(COORD_WIDTH - 1);
            end
            else if (cmd.mod_step)
                bit_cnt_reg <= bit_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= item_op;
            xchg_reg <= item_x != last_x_reg;
            zchg_reg <= item_z != last_z_reg;
            sx_reg   <= sx_w;
            sz_reg   <= sz_w;
            nx_reg   <= nx_w;
            nz_reg   <= nz_w;
            g_reg    <= g_eff;
            r2_reg   <= GRID_W'({r_eff, 1'b0});
        end
    end

    // Step a coordinate by one; on two's complement wrap the modulo restarts at MIN_NEG's.
    always_comb
    begin
        wx_next = wx_reg + COORD_WIDTH'(1);
        wz_next = wz_reg + COORD_WIDTH'(1);
        if (wx_reg == MAX_POS)
            mx_next = rem_reg[LANE_MIN];
        else if (mx_reg == g_reg - GRID_W'(1))
            mx_next = '0;
        else
            mx_next = mx_reg + GRID_W'(1);
        if (wz_reg == MAX_POS)
            mz_next = rem_reg[LANE_MIN];
        else if (mz_reg == g_reg - GRID_W'(1))
            mz_next = '0;
        else
            mz_next = mz_reg + GRID_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_init || cmd.start_z || cmd.row_reset)
        begin
            wx_reg <= sx_reg;
            mx_reg <= rem_reg[LANE_SX];
            i_reg  <= '0;
        end
        else if (cmd.step_i)
        begin
            wx_reg <= wx_next;
            mx_reg <= mx_next;
            i_reg  <= i_reg + GRID_W'(1);
        end

        if (cmd.start_init || cmd.start_x)
        begin
            wz_reg <= sz_reg;
            mz_reg <= rem_reg[LANE_SZ];
            j_reg  <= '0;
        end
        else if (cmd.step_j)
        begin
            wz_reg <= wz_next;
            mz_reg <= mz_next;
            j_reg  <= j_reg + GRID_W'(1);
        end
    end

    always_comb
    begin
        sel_x  = wx_reg;
        sel_z  = wz_reg;
        sel_mx = mx_reg;
        sel_mz = mz_reg;
        unique case (cmd.phase)
            PH_INIT:
            begin
            end
            PH_XS:
            begin
                sel_x  = nx_reg;
                sel_mx = rem_reg[LANE_OX];
            end
            PH_ZS:
            begin
                sel_z  = nz_reg;
                sel_mz = rem_reg[LANE_OZ];
            end
            default:
            begin
            end
        endcase
        slot_w = SLOT_W'(sel_mx) + SLOT_W'(g_reg) * SLOT_W'(sel_mz);
    end

    // Output register: the next result loads when the register is empty or the current one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            slot_reg <= slot_w;
            ox_reg_x <= sel_x;
            oz_reg_z <= sel_z;
            last_reg <= cmd.last;
        end
    end

    assign res_valid   = out_valid_reg;
    assign slot_index  = slot_reg;
    assign new_chunk_x = ox_reg_x;
    assign new_chunk_z = oz_reg_z;
    assign last        = last_reg;

    always_comb
    begin
        stat.mod_done = bit_cnt_reg == '0;
        stat.op       = op_reg;
        stat.xchg     = xchg_reg;
        stat.zchg     = zchg_reg;
        stat.row_end  = i_reg == r2_reg;
        stat.col_end  = j_reg == r2_reg;
        stat.can_emit = !out_valid_reg || res_ready;
    end

endmodule

`default_nettype wire

### design/tcss_controller.sv
// Controller: sequences modulo setup, init sweep and update strips.
`default_nettype none

module tcss_controller import tcss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_XS   = 3'd3;
    localparam logic [2:0] S_ZS   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.phase  = PH_INIT;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (!stat.mod_done)
                    cmd.mod_step = 1'b1;
                else if (stat.op == OP_INIT)
                begin
                    cmd.start_init = 1'b1;
                    state_next     = S_INIT;
                end
                else if (stat.xchg)
                begin
                    cmd.start_x = 1'b1;
                    state_next  = S_XS;
                end
                else if (stat.zchg)
                begin
                    cmd.start_z = 1'b1;
                    state_next  = S_ZS;
                end
                else
                    state_next = S_IDLE;
            end
            S_INIT:
            begin
                cmd.phase = PH_INIT;
                if (stat.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = stat.row_end && stat.col_end;
                    if (stat.row_end && stat.col_end)
                        state_next = S_IDLE;
                    else if (stat.row_end)
                    begin
                        cmd.row_reset = 1'b1;
                        cmd.step_j    = 1'b1;
                    end
                    else
                        cmd.step_i = 1'b1;
                end
            end
            S_XS:
            begin
                cmd.phase = PH_XS;
                if (stat.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = stat.col_end && !stat.zchg;
                    if (!stat.col_end)
                        cmd.step_j = 1'b1;
                    else if (stat.zchg)
                    begin
                        cmd.start_z = 1'b1;
                        state_next  = S_ZS;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_ZS:
            begin
                cmd.phase = PH_ZS;
                if (stat.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = stat.row_end;
                    if (stat.row_end)
                        state_next = S_IDLE;
                    else
                        cmd.step_i = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### design/toroidal_chunk_slot_scheduler.sv
// Chunk slot scheduler for a (2R+1)-square toroidal ring buffer of world chunks.
//
// Channels: item takes a request (op, chunk_x, chunk_z); result returns slot
// records (slot_index, new_chunk_x, new_chunk_z, last); cfg writes render_radius
// and is always ready. Write cfg only while the block is idle.
// An init request yields (2R+1)^2 results, z outer and x inner. An update yields
// 2R+1 results per changed axis, X strip first, or nothing if the position holds.
// After a request is taken, a bit-serial floored-modulo unit runs over the
// coordinate bits below the sign bit; then the result stream runs at one per
// cycle while the receiver keeps taking it, paced by the single output register.
// No new request is taken while one is in progress.
// A stalled receiver holds the result and halts the sweep; item stays not ready
// until the previous request has put its last result into the output register.
// Reset: position (0,0), radius 1, no result pending.
`default_nettype none
`include "toroidal_chunk_slot_scheduler_defines.svh"

module toroidal_chunk_slot_scheduler import tcss_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    tcss_item_if.sink    item,
    tcss_result_if.source result,
    tcss_cfg_if.sink     cfg
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    tcss_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    tcss_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .item_op     (item.op),
        .item_x      (item.chunk_x),
        .item_z      (item.chunk_z),
        .cfg_we      (cfg.valid),
        .cfg_radius  (cfg.render_radius),
        .res_ready   (result.ready),
        .res_valid   (result.valid),
        .slot_index  (result.slot_index),
        .new_chunk_x (result.new_chunk_x),
        .new_chunk_z (result.new_chunk_z),
        .last        (result.last)
    );

    `TCSS_ASSERT(a_busy_after_accept, item.valid && item.ready |=> !item.ready, "request accepted while busy")
    `TCSS_ASSERT(a_idle_after_last, cmd.emit && cmd.last |=> item.ready, "not idle after final result")
    `TCSS_ASSERT(a_no_emit_in_setup, !stat.mod_done |-> !cmd.emit, "result emitted during modulo setup")
    `TCSS_ASSERT(a_slot_range, result.valid |-> result.slot_index <= SLOT_W'(SLOT_MAX), "slot out of range")

endmodule

`default_nettype wire

### tb/sv/toroidal_chunk_slot_scheduler_tb.sv
// Testbench for the toroidal chunk slot scheduler: predicts and checks slot loads.
`timescale 1ns / 1ps

module toroidal_chunk_slot_scheduler_tb;
    import tcss_pkg::*;

    localparam int     LONG_HOLD     = 400;
    localparam int     SETTLE_CYCLES = 40;
    localparam coord_t COORD_HI      = coord_t'(24'h7FFFFF);
    localparam coord_t COORD_LO      = coord_t'(24'h800000);

    typedef struct {
        slot_t  slot;
        coord_t x;
        coord_t z;
        logic   last;
    } slot_load_t;

    // Predicts the slot loads of each request and matches them against the result stream.
    class chunk_slot_scoreboard;
        slot_load_t loads_q[$];
        coord_t     view_x;
        coord_t     view_z;
        radius_t    radius_reg;
        int         errors;

        function new();
            view_x     = '0;
            view_z     = '0;
            radius_reg = radius_t'(1);
            errors     = 0;
        endfunction

        function void set_radius(radius_t v);
            radius_reg = v;
        endfunction

        function int pending();
            return loads_q.size();
        endfunction

        function int grid_radius();
            int r;
            r = int'(radius_reg);
            if (r < 1)
                r = 1;
            if (r > MAX_RADIUS)
                r = MAX_RADIUS;
            return r;
        endfunction

        function slot_t slot_for(coord_t x, coord_t z, int g);
            int fx;
            int fz;
            fx = int'(x) % g;
            fz = int'(z) % g;
            if (fx < 0)
                fx += g;
            if (fz < 0)
                fz += g;
            return slot_t'(fx + g * fz);
        endfunction

        function void add_load(slot_t s, coord_t x, coord_t z);
            slot_load_t ld;
            ld.slot = s;
            ld.x    = x;
            ld.z    = z;
            ld.last = 1'b0;
            loads_q.insert(loads_q.size(), ld);
        endfunction

        function void record_request(logic op, coord_t cx, coord_t cz);
            int         r;
            int         g;
            int         d;
            int         n0;
            coord_t     wx;
            coord_t     wz;
            coord_t     lead;
            coord_t     trail;
            slot_load_t tail;
            r  = grid_radius();
            g  = 2 * r + 1;
            n0 = loads_q.size();
            if (op == OP_INIT)
            begin
                view_x = cx;
                view_z = cz;
                for (int j = -r; j <= r; j++)
                begin
                    for (int i = -r; i <= r; i++)
                    begin
                        wx = cx + coord_t'(i);
                        wz = cz + coord_t'(j);
                        add_load(slot_for(wx, wz, g), wx, wz);
                    end
                end
            end
            else
            begin
                if (cx != view_x)
                begin
                    d     = (cx > view_x) ? 1 : -1;
                    lead  = cx + coord_t'(r * d);
                    trail = view_x + coord_t'(-r * d);
                    for (int j = -r; j <= r; j++)
                    begin
                        wz = cz + coord_t'(j);
                        add_load(slot_for(trail, wz, g), lead, wz);
                    end
                    view_x = cx;
                end
                if (cz != view_z)
                begin
                    d     = (cz > view_z) ? 1 : -1;
                    lead  = cz + coord_t'(r * d);
                    trail = view_z + coord_t'(-r * d);
                    for (int i = -r; i <= r; i++)
                    begin
                        wx = cx + coord_t'(i);
                        add_load(slot_for(wx, trail, g), wx, lead);
                    end
                    view_z = cz;
                end
            end
            // Flag the final load of this request.
            if (loads_q.size() > n0)
            begin
                tail      = loads_q[loads_q.size() - 1];
                tail.last = 1'b1;
                loads_q[loads_q.size() - 1] = tail;
            end
        endfunction

        function void check_load(slot_t s, coord_t x, coord_t z, logic last);
            slot_load_t want;
            if (loads_q.size() == 0)
            begin
                $display("%0t unexpected result: slot %0d x %0d z %0d last %0b",
                         $time, s, x, z, last);
                errors++;
                return;
            end
            want = loads_q.pop_front();
            if (s !== want.slot)
            begin
                $display("%0t slot_index mismatch: expected %0d actual %0d",
                         $time, want.slot, s);
                errors++;
            end
            if (x !== want.x)
            begin
                $display("%0t new_chunk_x mismatch: expected %0d actual %0d",
                         $time, want.x, x);
                errors++;
            end
            if (z !== want.z)
            begin
                $display("%0t new_chunk_z mismatch: expected %0d actual %0d",
                         $time, want.z, z);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t last mismatch: expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tcss_item_if   item_ch();
    tcss_result_if res_ch();
    tcss_cfg_if    cfg_ch();

    chunk_slot_scoreboard sb = new();

    int burst_left    = 0;
    bit long_hold_req = 1'b0;

    toroidal_chunk_slot_scheduler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #4 clk = ~clk;

    initial
    begin : watchdog
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Take a result on every edge where the handshake completes.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_load(res_ch.slot_index, res_ch.new_chunk_x, res_ch.new_chunk_z,
                          res_ch.last);
    end

    initial
    begin : result_sink
        int mode;
        int mode_left;
        int hold_left;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && hold_left == 0)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
                if (hold_left == 0)
                    long_hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0:       res_ch.ready = 1'b1;
                    1:       res_ch.ready = ($urandom_range(0, 3) != 0);
                    2:       res_ch.ready = ($urandom_range(0, 1) == 1);
                    default: res_ch.ready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic hold_off(input int n);
        repeat (n)
        begin
            @(negedge clk);
            item_ch.valid = 1'b0;
        end
    endtask

    task automatic send_request(input logic op, input coord_t x, input coord_t z);
        @(negedge clk);
        item_ch.valid   = 1'b1;
        item_ch.op      = op;
        item_ch.chunk_x = x;
        item_ch.chunk_z = z;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.record_request(op, x, z);
    endtask

    // Send in bursts, with a random gap, sometimes none, before each burst.
    task automatic offer(input logic op, input coord_t x, input coord_t z);
        if (burst_left == 0)
        begin
            hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_request(op, x, z);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // An update that holds its position leaves no result; let it finish.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radius(input radius_t v);
        @(negedge clk);
        cfg_ch.valid         = 1'b1;
        cfg_ch.render_radius = v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.set_radius(v);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic coord_t next_coord(coord_t cur);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 16)
            return cur + coord_t'(int'($urandom_range(0, 2)) - 1);
        else if (sel == 16)
            return cur + coord_t'(int'($urandom_range(0, 20)) - 10);
        else if (sel == 17)
            return coord_t'($urandom);
        else if (sel == 18)
            return COORD_HI - coord_t'($urandom_range(0, 3));
        else
            return COORD_LO + coord_t'($urandom_range(0, 3));
    endfunction

    initial
    begin : stimulus
        coord_t  gx;
        coord_t  gz;
        logic    op;
        radius_t seg_radius;

        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.op           = OP_INIT;
        item_ch.chunk_x      = '0;
        item_ch.chunk_z      = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.render_radius = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset radius; updates before any init work against the origin.
        offer(OP_UPDATE, coord_t'(0), coord_t'(0));
        offer(OP_UPDATE, coord_t'(1), coord_t'(0));
        offer(OP_UPDATE, coord_t'(1), coord_t'(2));
        offer(OP_UPDATE, coord_t'(-3), coord_t'(-5));
        offer(OP_INIT, coord_t'(0), coord_t'(0));
        offer(OP_UPDATE, coord_t'(0), coord_t'(0));
        wait_drained();

        // Largest grid, coordinates at the wrap point.
        write_radius(radius_t'(3));
        offer(OP_INIT, COORD_HI, COORD_HI);
        offer(OP_UPDATE, COORD_LO, COORD_LO);
        offer(OP_UPDATE, COORD_LO, COORD_HI);
        offer(OP_INIT, COORD_LO, COORD_LO);
        offer(OP_UPDATE, COORD_HI, COORD_LO);
        wait_drained();

        // Zero radius reads as one.
        write_radius(radius_t'(0));
        offer(OP_INIT, coord_t'(-1), coord_t'(-1));
        offer(OP_UPDATE, coord_t'(0), coord_t'(-1));
        offer(OP_UPDATE, coord_t'(-1), coord_t'(0));
        wait_drained();

        write_radius(radius_t'(2));
        offer(OP_INIT, coord_t'(5), coord_t'(-7));
        offer(OP_UPDATE, coord_t'(6), coord_t'(-7));
        offer(OP_UPDATE, coord_t'(6), coord_t'(-6));
        offer(OP_UPDATE, coord_t'(4), coord_t'(-9));
        gx = coord_t'(4);
        gz = coord_t'(-9);

        for (int seg = 0; seg < 5; seg++)
        begin
            wait_drained();
            case (seg)
                0:       seg_radius = radius_t'(1);
                1:       seg_radius = radius_t'(3);
                2:       seg_radius = radius_t'(0);
                3:       seg_radius = radius_t'(2);
                default: seg_radius = radius_t'($urandom_range(0, 3));
            endcase
            write_radius(seg_radius);
            // Open each phase with an init so the updates walk a placed viewer.
            gx = ($urandom_range(0, 1) == 0) ? next_coord(gx) : coord_t'($urandom);
            gz = ($urandom_range(0, 1) == 0) ? next_coord(gz) : coord_t'($urandom);
            offer(OP_INIT, gx, gz);
            for (int k = 0; k < 30; k++)
            begin
                op = ($urandom_range(0, 9) == 0) ? OP_INIT : OP_UPDATE;
                gx = next_coord(gx);
                gz = next_coord(gz);
                offer(op, gx, gz);
                if (seg == 1 && k == 4)
                    long_hold_req = 1'b1;
                if (seg == 3 && k == 12)
                    wait_drained();
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### toroidal_chunk_slot_scheduler.f
+incdir+design
design/tcss_pkg.sv
design/tcss_intf.sv
design/tcss_datapath.sv
design/tcss_controller.sv
design/toroidal_chunk_slot_scheduler.sv
tb/sv/toroidal_chunk_slot_scheduler_tb.sv
